// File: src/bitmap_frame_allocator_assert.svh
// Assertion macros for the bitmap frame allocator.
// Used by the top level; no other dependencies.
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define BFA_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bitmap frame allocator assertion failed");
// Next-cycle implication, disabled during reset.
`define BFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bitmap frame allocator assertion failed");
`else
`define BFA_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define BFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int FRAME_W   = 20;
    localparam int COUNT_W   = 14;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MARK    = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_RELEASE = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_RANGE   = 2'd3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_POOL_BASE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POOL_COUNT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESERVED   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HOLE_START = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HOLE_COUNT = 3'd4;

    // Register reset values
    localparam logic [FRAME_W-1:0] RST_POOL_BASE  = 20'd512;
    localparam logic [COUNT_W-1:0] RST_POOL_COUNT = 14'd512;
    localparam logic [FRAME_W-1:0] RST_RESERVED   = 20'd512;
    localparam logic [FRAME_W-1:0] RST_HOLE_START = 20'd3840;
    localparam logic [COUNT_W-1:0] RST_HOLE_COUNT = 14'd256;

    typedef struct packed {
        logic [FRAME_W-1:0] pool_base;
        logic [COUNT_W-1:0] pool_count;
        logic [FRAME_W-1:0] reserved;
        logic [FRAME_W-1:0] hole_start;
        logic [COUNT_W-1:0] hole_count;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;   // capture the input transfer
        logic setup;     // check bounds, set walk range, rewind walk
        logic step;      // issue the next bitmap word read
        logic eval;      // update the word read last cycle
        logic clear;     // clearing pass: zero one word
        logic load_out;  // move result into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last; // clearing pass is at the last word
        logic more;       // words left to read in the walk
        logic pending;    // a read word waits for update
        logic found;      // allocate found a free frame
    } dp_status_t;

endpackage

// File: src/bfa_regs.sv
// APB configuration registers of the bitmap frame allocator.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_regs
    import bfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_POOL_BASE:  cfg_next.pool_base  = pwdata[FRAME_W-1:0];
                REG_POOL_COUNT: cfg_next.pool_count = pwdata[COUNT_W-1:0];
                REG_RESERVED:   cfg_next.reserved   = pwdata[FRAME_W-1:0];
                REG_HOLE_START: cfg_next.hole_start = pwdata[FRAME_W-1:0];
                REG_HOLE_COUNT: cfg_next.hole_count = pwdata[COUNT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_POOL_BASE:  prdata = DATA_W'(cfg_reg.pool_base);
            REG_POOL_COUNT: prdata = DATA_W'(cfg_reg.pool_count);
            REG_RESERVED:   prdata = DATA_W'(cfg_reg.reserved);
            REG_HOLE_START: prdata = DATA_W'(cfg_reg.hole_start);
            REG_HOLE_COUNT: prdata = DATA_W'(cfg_reg.hole_count);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pool_base  <= RST_POOL_BASE;
            cfg_reg.pool_count <= RST_POOL_COUNT;
            cfg_reg.reserved   <= RST_RESERVED;
            cfg_reg.hole_start <= RST_HOLE_START;
            cfg_reg.hole_count <= RST_HOLE_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/bfa_ctrl.sv
// Controller state machine of the bitmap frame allocator.
// Depends on bfa_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  dp_status_t sts,
    output ctrl_cmd_t  ctrl
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_vld_reg;
    logic       out_vld_next;

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_vld_reg;

    always_comb
    begin
        state_next   = state_reg;
        out_vld_next = out_vld_reg;
        ctrl         = '0;
        if (out_vld_reg && !rsp_stall)
        begin
            out_vld_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                ctrl.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctrl.load_in = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctrl.setup = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                ctrl.step = 1'b1;
                ctrl.eval = 1'b1;
                if (sts.found || (!sts.more && !sts.pending))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register frees up
                if (!out_vld_reg || !rsp_stall)
                begin
                    ctrl.load_out = 1'b1;
                    out_vld_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

// File: src/bfa_dp.sv
// Datapath of the bitmap frame allocator: bitmap memory, word walker,
// bounds checks and result registers. Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_dp
    import bfa_pkg::*;
#(
    parameter int MAX_FRAMES = 8192,
    parameter int WORD_BITS  = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          ctrl,
    output dp_status_t         sts,
    input  cfg_t               cfg,
    input  logic [CMD_W-1:0]   command,
    input  logic [FRAME_W-1:0] frame_no,
    input  logic [COUNT_W-1:0] frame_count,
    output logic [FRAME_W-1:0] result_frame,
    output logic [STAT_W-1:0]  status
);

    localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = COUNT_W + 1;
    localparam int JW    = $clog2(WORD_BITS);
    localparam int XW    = FRAME_W + 1;

    // bitmap, bit set = frame used
    logic [WORD_BITS-1:0] mem [WORDS];

    // captured item
    logic [CMD_W-1:0]     cmd_in_reg;
    logic [FRAME_W-1:0]   fno_reg;
    logic [COUNT_W-1:0]   cnt_reg;

    // walk setup
    logic [CMD_W-1:0]     mode_reg;
    logic [COUNT_W-1:0]   lo_reg;
    logic [COUNT_W-1:0]   hi_reg;
    logic [COUNT_W-1:0]   pt_reg;
    logic                 pt_en_reg;
    logic [STAT_W-1:0]    sta_reg;
    logic [FRAME_W-1:0]   res_reg;

    // walk position and read stage
    logic [AW-1:0]        word_reg;
    logic [BW-1:0]        base_reg;
    logic                 ev_vld_reg;
    logic [AW-1:0]        ev_word_reg;
    logic [BW-1:0]        ev_base_reg;
    logic [WORD_BITS-1:0] rdata_reg;

    // output register
    logic [FRAME_W-1:0]   out_res_reg;
    logic [STAT_W-1:0]    out_sta_reg;

    // setup logic
    logic [COUNT_W-1:0]   pool_n;
    logic [XW-1:0]        pool_end;
    logic [XW-1:0]        hole_end;
    logic [XW-1:0]        range_end;
    logic                 in_hole;
    logic                 in_pool;
    logic                 rsv_in_pool;
    logic                 range_ok;
    logic [COUNT_W-1:0]   fno_rel;
    logic [COUNT_W-1:0]   rsv_rel;
    logic [CMD_W-1:0]     mode_next;
    logic [COUNT_W-1:0]   lo_next;
    logic [COUNT_W-1:0]   hi_next;
    logic                 pt_en_next;
    logic [STAT_W-1:0]    sta_next;

    // word update logic
    logic [BW-1:0]        bit_idx [WORD_BITS];
    logic [WORD_BITS-1:0] rng;
    logic [WORD_BITS-1:0] pt_hit;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] lowest;
    logic [JW-1:0]        low_pos;
    logic [WORD_BITS-1:0] new_word;
    logic [FRAME_W-1:0]   alloc_frame;
    logic                 found;
    logic                 more;

    // memory port
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;

    // ---- bounds checks ----
    always_comb
    begin
        if (32'(cfg.pool_count) > 32'(MAX_FRAMES))
        begin
            pool_n = COUNT_W'(MAX_FRAMES);
        end
        else
        begin
            pool_n = cfg.pool_count;
        end
        pool_end    = {1'b0, cfg.pool_base} + XW'(pool_n);
        hole_end    = {1'b0, cfg.hole_start} + XW'(cfg.hole_count);
        range_end   = {1'b0, fno_reg} + XW'(cnt_reg);
        in_hole     = (fno_reg >= cfg.hole_start) && ({1'b0, fno_reg} < hole_end);
        in_pool     = (fno_reg >= cfg.pool_base) && ({1'b0, fno_reg} < pool_end);
        rsv_in_pool = (cfg.reserved >= cfg.pool_base) && ({1'b0, cfg.reserved} < pool_end);
        range_ok    = (fno_reg >= cfg.pool_base) && (range_end <= pool_end);
        fno_rel     = COUNT_W'(fno_reg - cfg.pool_base);
        rsv_rel     = COUNT_W'(cfg.reserved - cfg.pool_base);
    end

    // ---- walk range per command ----
    always_comb
    begin
        mode_next  = cmd_in_reg;
        lo_next    = '0;
        hi_next    = '0;
        pt_en_next = 1'b0;
        sta_next   = ST_OK;
        case (cmd_in_reg)
            CMD_INIT:
            begin
                hi_next    = pool_n;
                pt_en_next = rsv_in_pool;
            end
            CMD_ALLOC:
            begin
                hi_next  = pool_n;
                sta_next = ST_NO_FREE;
            end
            CMD_RELEASE:
            begin
                if (in_hole || !in_pool || (fno_reg == cfg.reserved))
                begin
                    sta_next = ST_BAD_RELEASE;
                end
                else
                begin
                    lo_next = fno_rel;
                    hi_next = fno_rel + COUNT_W'(1);
                end
            end
            CMD_MARK:
            begin
                if (cnt_reg != '0)
                begin
                    if (range_ok)
                    begin
                        lo_next = fno_rel;
                        hi_next = fno_rel + cnt_reg;
                    end
                    else
                    begin
                        sta_next = ST_BAD_RANGE;
                    end
                end
            end
            default:
            begin
                hi_next = '0;
            end
        endcase
    end

    // ---- word update ----
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            bit_idx[j] = ev_base_reg + BW'(j);
            rng[j]     = (bit_idx[j] >= {1'b0, lo_reg}) && (bit_idx[j] < {1'b0, hi_reg});
            pt_hit[j]  = pt_en_reg && (bit_idx[j] == {1'b0, pt_reg});
        end
        free_bits = ~rdata_reg & rng;
        lowest    = free_bits & (~free_bits + WORD_BITS'(1));
        low_pos   = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                low_pos = JW'(j);
            end
        end
        case (mode_reg)
            CMD_INIT:    new_word = (rdata_reg & ~rng) | pt_hit;
            CMD_ALLOC:   new_word = rdata_reg | lowest;
            CMD_RELEASE: new_word = rdata_reg & ~rng;
            CMD_MARK:    new_word = rdata_reg | rng;
            default:     new_word = rdata_reg;
        endcase
        alloc_frame = cfg.pool_base + FRAME_W'(ev_base_reg) + FRAME_W'(low_pos);
        found       = (mode_reg == CMD_ALLOC) && ev_vld_reg && (free_bits != '0);
    end

    assign more = (base_reg < {1'b0, hi_reg});

    assign sts.clear_last = (word_reg == AW'(WORDS - 1));
    assign sts.more       = more;
    assign sts.pending    = ev_vld_reg;
    assign sts.found      = found;

    // ---- memory port ----
    assign mem_re = ctrl.step && more;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ev_word_reg;
        mem_wdata = new_word;
        if (ctrl.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = word_reg;
            mem_wdata = '0;
        end
        else if (ctrl.eval && ev_vld_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[word_reg];
        end
    end

    // ---- walk control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg   <= '0;
            base_reg   <= '0;
            ev_vld_reg <= 1'b0;
            hi_reg     <= '0;
        end
        else
        begin
            ev_vld_reg <= mem_re;
            if (ctrl.setup)
            begin
                word_reg <= '0;
                base_reg <= '0;
                hi_reg   <= hi_next;
            end
            else if (ctrl.clear || mem_re)
            begin
                word_reg <= word_reg + AW'(1);
                base_reg <= base_reg + BW'(WORD_BITS);
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            cmd_in_reg <= command;
            fno_reg    <= frame_no;
            cnt_reg    <= frame_count;
        end
        if (ctrl.setup)
        begin
            mode_reg  <= mode_next;
            lo_reg    <= lo_next;
            pt_reg    <= rsv_rel;
            pt_en_reg <= pt_en_next;
            sta_reg   <= sta_next;
            res_reg   <= '0;
        end
        else if (ctrl.eval && found)
        begin
            res_reg <= alloc_frame;
            sta_reg <= ST_OK;
        end
        if (mem_re)
        begin
            ev_word_reg <= word_reg;
            ev_base_reg <= base_reg;
        end
        if (ctrl.load_out)
        begin
            out_res_reg <= res_reg;
            out_sta_reg <= sta_reg;
        end
    end

    assign result_frame = out_res_reg;
    assign status       = out_sta_reg;

endmodule

// File: src/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: APB registers, controller, datapath.
// Depends on bfa_pkg, bfa_regs, bfa_ctrl, bfa_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "bitmap_frame_allocator_assert.svh"

// Usage:
//  Command channel (cmd_valid/cmd_stall): command, frame_no, frame_count. A transfer
//  completes at a clock edge with cmd_valid high and cmd_stall low.
//  Response channel (rsp_valid/rsp_stall): result_frame and status, one per command.
//  An item walks the bitmap memory one word per cycle from word 0 up to the
//  last word its command touches: the words holding the pool for init and a full
//  allocate, fewer when allocate hits early, up to the word of the last frame for
//  release and mark. Bounds failures and empty ranges walk no word. One item is
//  processed at a time; the next command can be taken in the cycle after the
//  result moves out. The output register lets the next command be accepted while
//  a response waits.
//  Reset: registers take their reset values, then a clearing pass zeroes the bitmap,
//  one word per cycle, (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS words (256 with the
//  defaults); cmd_stall stays high meanwhile, APB writes are taken as ever.
//  When the receiver stalls, the response holds; one more command can be processed
//  and then waits in the controller until the output register frees up.
//  Configure only while the block is idle.
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int MAX_FRAMES = 8192,
    parameter int WORD_BITS  = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // command channel
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [FRAME_W-1:0] frame_no,
    input  logic [COUNT_W-1:0] frame_count,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [FRAME_W-1:0] result_frame,
    output logic [STAT_W-1:0]  status
);

    cfg_t       cfg;
    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_sts;

    // Configuration registers
    bfa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencing: clearing pass, accept, check, walk, respond
    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (dp_sts),
        .ctrl      (ctrl_cmd)
    );

    // Bitmap memory and word update
    bfa_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_cmd),
        .sts          (dp_sts),
        .cfg          (cfg),
        .command      (command),
        .frame_no     (frame_no),
        .frame_count  (frame_count),
        .result_frame (result_frame),
        .status       (status)
    );

    // One item in flight: an accepted transfer closes the command channel.
    `BFA_ASSERT_NEXT(a_one_item, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall)
    // Failed commands, allocate with no free frame included, report frame zero.
    `BFA_ASSERT_IMPLIES(a_zero_on_fail, clk, rst_n, rsp_valid && (status != ST_OK) && (status != ST_NO_FREE) || rsp_valid && (status == ST_NO_FREE), result_frame == '0)
    // Never overwrite a response that is still waiting.
    `BFA_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, ctrl_cmd.load_out, !rsp_valid || !rsp_stall)

endmodule
